FILE: sv/affine_2d_transform_builder_top_defines.svh
//----------------------------------------------------------------------------
// Assertion macros for the affine transform builder
// Short forms for the clocked assertions used across the RTL folder.
//----------------------------------------------------------------------------
`ifndef AFFINE_2D_TRANSFORM_BUILDER_TOP_DEFINES_SVH
`define AFFINE_2D_TRANSFORM_BUILDER_TOP_DEFINES_SVH

// Condition holds at every edge outside reset.
`define A2T_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define A2T_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/a2t_pkg.sv
//----------------------------------------------------------------------------
// a2t_pkg
// Types, constants and helpers shared by the affine transform builder.
//----------------------------------------------------------------------------
package a2t_pkg;

    localparam int ANG_W      = 32;  // angle in units of 2^-22 degree
    localparam int XY_W       = 33;  // CORDIC x, y, Q2.30 plus guard bit
    localparam int ATAN_W     = 28;
    localparam int MAX_STAGES = 24;

    localparam logic signed [XY_W-1:0]  KGAIN  = 33'sd652032874;
    localparam logic signed [ANG_W:0]   DEG90  = 33'sd377487360;
    localparam logic signed [ANG_W:0]   DEG180 = 33'sd754974720;
    localparam logic signed [ANG_W:0]   DEG360 = 33'sd1509949440;

    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [25:0] rot;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } t_req;

    // Operands that ride along with the rotation
    typedef struct packed {
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic               ovf;
        logic               neg;
    } t_side;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        t_side                   side;
    } t_rot;

    typedef struct packed {
        logic signed [23:0] m00;
        logic signed [23:0] m01;
        logic signed [23:0] m10;
        logic signed [23:0] m11;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic               ovf;
    } t_res;

    // atan(2^-i) in degrees, units of 2^-22 degree
    function automatic logic [ATAN_W-1:0] atan_deg(input int unsigned idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = 28'd188743680;
            1:       v = 28'd111421900;
            2:       v = 28'd58872272;
            3:       v = 28'd29884485;
            4:       v = 28'd15000234;
            5:       v = 28'd7507429;
            6:       v = 28'd3754631;
            7:       v = 28'd1877430;
            8:       v = 28'd938729;
            9:       v = 28'd469366;
            10:      v = 28'd234683;
            11:      v = 28'd117342;
            12:      v = 28'd58671;
            13:      v = 28'd29335;
            14:      v = 28'd14668;
            15:      v = 28'd7334;
            16:      v = 28'd3667;
            17:      v = 28'd1833;
            18:      v = 28'd917;
            19:      v = 28'd458;
            20:      v = 28'd229;
            21:      v = 28'd115;
            22:      v = 28'd57;
            23:      v = 28'd29;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp to 32 bits signed; bit 32 of the result flags a clamp
    function automatic logic [32:0] sat32(input logic signed [39:0] v);
        logic [32:0] r;
        if (v > 40'sh00_7FFF_FFFF) begin
            r = {1'b1, T_MAX};
        end else if (v < -40'sh00_8000_0000) begin
            r = {1'b1, T_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

FILE: sv/a2t_pre.sv
//----------------------------------------------------------------------------
// a2t_pre
// Angle folding into a quarter turn and pivot scaling ahead of the CORDIC.
//----------------------------------------------------------------------------
`include "affine_2d_transform_builder_top_defines.svh"

module a2t_pre (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  a2t_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output a2t_pkg::t_rot   o_rot
);

    // stage A: fold angle, multiply pivot by scale
    logic                           r_va;
    logic signed [55:0]             r_prod_x, r_prod_y;
    logic signed [a2t_pkg::ANG_W-1:0] r_z;
    logic                           r_neg;
    logic signed [23:0]             r_sx, r_sy;
    logic signed [31:0]             r_qx, r_qy;

    // stage B: round and clamp the scaled pivot
    logic                           r_vb;
    a2t_pkg::t_rot                  r_rot;

    logic                           w_rdy_b;
    logic signed [a2t_pkg::ANG_W:0] w_a0, w_a1, w_a2;
    logic                           n_neg;
    logic signed [55:0]             n_prod_x, n_prod_y;
    logic signed [55:0]             w_rx, w_ry;
    logic [32:0]                    w_sat_x, w_sat_y;
    a2t_pkg::t_rot                  n_rot;

    assign w_rdy_b = !r_vb || i_ready;
    assign o_ready = !r_va || w_rdy_b;

    always_comb begin
        w_a0 = $signed({i_req.rot[25], i_req.rot, 6'b0});
        if (w_a0 > a2t_pkg::DEG180) begin
            w_a1 = w_a0 - a2t_pkg::DEG360;
        end else if (w_a0 < -a2t_pkg::DEG180) begin
            w_a1 = w_a0 + a2t_pkg::DEG360;
        end else begin
            w_a1 = w_a0;
        end
        if (w_a1 > a2t_pkg::DEG90) begin
            w_a2  = w_a1 - a2t_pkg::DEG180;
            n_neg = 1'b1;
        end else if (w_a1 < -a2t_pkg::DEG90) begin
            w_a2  = w_a1 + a2t_pkg::DEG180;
            n_neg = 1'b1;
        end else begin
            w_a2  = w_a1;
            n_neg = 1'b0;
        end
        n_prod_x = i_req.px * i_req.sx;
        n_prod_y = i_req.py * i_req.sy;
    end

    always_comb begin
        w_rx    = r_prod_x + 56'sd32768;
        w_ry    = r_prod_y + 56'sd32768;
        w_sat_x = a2t_pkg::sat32(w_rx[55:16]);
        w_sat_y = a2t_pkg::sat32(w_ry[55:16]);
        n_rot.x        = a2t_pkg::KGAIN;
        n_rot.y        = '0;
        n_rot.z        = r_z;
        n_rot.side.sx  = r_sx;
        n_rot.side.sy  = r_sy;
        n_rot.side.qx  = r_qx;
        n_rot.side.qy  = r_qy;
        n_rot.side.ax  = $signed(w_sat_x[31:0]);
        n_rot.side.ay  = $signed(w_sat_y[31:0]);
        n_rot.side.ovf = w_sat_x[32] | w_sat_y[32];
        n_rot.side.neg = r_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (o_ready) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_z      <= w_a2[a2t_pkg::ANG_W-1:0];
            r_neg    <= n_neg;
            r_sx     <= i_req.sx;
            r_sy     <= i_req.sy;
            r_qx     <= i_req.qx;
            r_qy     <= i_req.qy;
        end
        if (w_rdy_b) begin
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_vb;
    assign o_rot   = r_rot;

    `A2T_ASSERT_IMPLIES(a_angle_folded, i_clk, i_rst_n, r_va,
        r_z <= a2t_pkg::DEG90 && r_z >= -a2t_pkg::DEG90, "angle not folded to quarter turn")
    `A2T_ASSERT_IMPLIES(a_ovf_on_rail, i_clk, i_rst_n, r_vb && r_rot.side.ovf,
        r_rot.side.ax == a2t_pkg::T_MAX || r_rot.side.ax == a2t_pkg::T_MIN || r_rot.side.ay == a2t_pkg::T_MAX || r_rot.side.ay == a2t_pkg::T_MIN, "overflow without clamped pivot")

endmodule

FILE: sv/a2t_cell.sv
//----------------------------------------------------------------------------
// a2t_cell
// One CORDIC rotation micro-step with its own pipeline register.
//----------------------------------------------------------------------------
`include "affine_2d_transform_builder_top_defines.svh"

module a2t_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  a2t_pkg::t_rot   i_rot,
    output logic            o_valid,
    input  logic            i_ready,
    output a2t_pkg::t_rot   o_rot
);

    logic                             r_v;
    a2t_pkg::t_rot                    r_rot;
    a2t_pkg::t_rot                    n_rot;
    logic signed [a2t_pkg::XY_W-1:0]  w_dx, w_dy;
    logic signed [a2t_pkg::ANG_W-1:0] w_step;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        w_dx   = i_rot.y >>> IDX;
        w_dy   = i_rot.x >>> IDX;
        w_step = $signed({{(a2t_pkg::ANG_W - a2t_pkg::ATAN_W){1'b0}}, a2t_pkg::atan_deg(IDX)});
        n_rot  = i_rot;
        // rotate toward zero residual angle
        if (!i_rot.z[a2t_pkg::ANG_W-1]) begin
            n_rot.x = i_rot.x - w_dx;
            n_rot.y = i_rot.y + w_dy;
            n_rot.z = i_rot.z - w_step;
        end else begin
            n_rot.x = i_rot.x + w_dx;
            n_rot.y = i_rot.y - w_dy;
            n_rot.z = i_rot.z + w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_v;
    assign o_rot   = r_rot;

    `A2T_ASSERT_IMPLIES(a_xy_headroom, i_clk, i_rst_n, r_v,
        r_rot.x[a2t_pkg::XY_W-1] == r_rot.x[a2t_pkg::XY_W-2] && r_rot.y[a2t_pkg::XY_W-1] == r_rot.y[a2t_pkg::XY_W-2], "CORDIC vector out of range")

endmodule

FILE: sv/a2t_post.sv
//----------------------------------------------------------------------------
// a2t_post
// Sign fix of sine and cosine, matrix and translation products, rounding
// and clamping into the result register.
//----------------------------------------------------------------------------
module a2t_post (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  a2t_pkg::t_rot   i_rot,
    output logic            o_valid,
    input  logic            i_ready,
    output a2t_pkg::t_res   o_res
);

    localparam int PM_W = 24 + a2t_pkg::XY_W;   // scale times trig
    localparam int PT_W = 32 + a2t_pkg::XY_W;   // pivot times trig

    function automatic logic signed [23:0] sat24(input logic signed [PM_W-31:0] v);
        logic signed [23:0] r;
        if (v > $signed((PM_W-30)'(24'sh7F_FFFF))) begin
            r = 24'sh7F_FFFF;
        end else if (v < $signed((PM_W-30)'(24'sh80_0000))) begin
            r = 24'sh80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // P0: signed sine and cosine
    logic                             r_v0;
    logic signed [a2t_pkg::XY_W-1:0]  r_c, r_s, r_ns;
    a2t_pkg::t_side                   r_side0;

    // P1: products
    logic                             r_v1;
    logic signed [PM_W-1:0]           r_pm00, r_pm01, r_pm10, r_pm11;
    logic signed [PT_W-1:0]           r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [31:0]               r_qx1, r_qy1;
    logic                             r_ovf1;

    // P2: matrix clamp, translation sums
    logic                             r_v2;
    logic signed [23:0]               r_m00, r_m01, r_m10, r_m11;
    logic signed [PT_W:0]             r_sum_x, r_sum_y;
    logic signed [31:0]               r_qx2, r_qy2;
    logic                             r_ovf2;

    // P3: result register
    logic                             r_v3;
    a2t_pkg::t_res                    r_res;

    logic                             w_rdy0, w_rdy1, w_rdy2, w_rdy3;
    logic signed [PM_W-1:0]           w_r00, w_r01, w_r10, w_r11;
    logic signed [PT_W:0]             w_rx, w_ry;
    logic signed [PT_W-30:0]          w_tx, w_ty;
    logic [32:0]                      w_sat_x, w_sat_y;
    a2t_pkg::t_res                    n_res;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;

    always_comb begin
        w_r00 = r_pm00 + PM_W'(64'sd536870912);
        w_r01 = r_pm01 + PM_W'(64'sd536870912);
        w_r10 = r_pm10 + PM_W'(64'sd536870912);
        w_r11 = r_pm11 + PM_W'(64'sd536870912);
        w_rx  = r_sum_x + (PT_W+1)'(64'sd536870912);
        w_ry  = r_sum_y + (PT_W+1)'(64'sd536870912);
        w_tx  = w_rx[PT_W:30] + {{(PT_W-61){r_qx2[31]}}, r_qx2};
        w_ty  = w_ry[PT_W:30] + {{(PT_W-61){r_qy2[31]}}, r_qy2};
        w_sat_x = a2t_pkg::sat32(40'(w_tx));
        w_sat_y = a2t_pkg::sat32(40'(w_ty));
        n_res.m00 = r_m00;
        n_res.m01 = r_m01;
        n_res.m10 = r_m10;
        n_res.m11 = r_m11;
        n_res.tx  = $signed(w_sat_x[31:0]);
        n_res.ty  = $signed(w_sat_y[31:0]);
        n_res.ovf = r_ovf2 | w_sat_x[32] | w_sat_y[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_valid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_c     <= i_rot.side.neg ? -i_rot.x : i_rot.x;
            r_s     <= i_rot.side.neg ? -i_rot.y : i_rot.y;
            r_ns    <= i_rot.side.neg ? i_rot.y : -i_rot.y;
            r_side0 <= i_rot.side;
        end
        if (w_rdy1) begin
            r_pm00 <= r_side0.sx * r_c;
            r_pm01 <= r_side0.sx * r_s;
            r_pm10 <= r_side0.sy * r_ns;
            r_pm11 <= r_side0.sy * r_c;
            r_pxc  <= r_side0.ax * r_c;
            r_pys  <= r_side0.ay * r_s;
            r_pxs  <= r_side0.ax * r_s;
            r_pyc  <= r_side0.ay * r_c;
            r_qx1  <= r_side0.qx;
            r_qy1  <= r_side0.qy;
            r_ovf1 <= r_side0.ovf;
        end
        if (w_rdy2) begin
            r_m00   <= sat24(w_r00[PM_W-1:30]);
            r_m01   <= sat24(w_r01[PM_W-1:30]);
            r_m10   <= sat24(w_r10[PM_W-1:30]);
            r_m11   <= sat24(w_r11[PM_W-1:30]);
            r_sum_x <= r_pxc - r_pys;
            r_sum_y <= r_pxs + r_pyc;
            r_qx2   <= r_qx1;
            r_qy2   <= r_qy1;
            r_ovf2  <= r_ovf1;
        end
        if (w_rdy3) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

FILE: sv/affine_2d_transform_builder_top.sv
//----------------------------------------------------------------------------
// affine_2d_transform_builder_top
// Builds the 2D local transform (pivot, scale, rotate about Z, translate)
// as a 2x2 linear part plus a saturated translation, one request per cycle unless the output is held.
//----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake                       Content
//  s_axis    in    s_axis_tvalid / s_axis_tready   pivot, scale, angle, pos
//  m_axis    out   m_axis_tvalid / m_axis_tready   matrix, translation, flag
//
//  One request enters per cycle and one result leaves per cycle while the output is not held.
//  The pipe has two front stages (angle fold and pivot multiply, then
//  pivot clamp), one cell per CORDIC micro-step, and four back stages
//  (sign fix, products, matrix clamp and sums, result).
//  Every stage carries its own valid bit; a stage loads whenever it is empty
//  or its successor loads, so bubbles collapse and a held result stalls only
//  the requests queued behind it.
//  Reset clears the valid bits only; data registers are not reset.
//----------------------------------------------------------------------------
`include "affine_2d_transform_builder_top_defines.svh"

module affine_2d_transform_builder_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pivot_x[31:0] pivot_y[63:32] scale_x[87:64] scale_y[111:88]
    // rotation_deg[137:112] pos_x[169:138] pos_y[201:170], zero pad above
    input  logic [207:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // m00[23:0] m01[47:24] m10[71:48] m11[95:72] trans_x[127:96] trans_y[159:128]
    output logic [159:0] m_axis_tdata,
    // overflow[0]
    output logic [0:0]   m_axis_tuser
);

    // stages beyond the arctangent table are not run
    localparam int N_CELLS = (CORDIC_STAGES > a2t_pkg::MAX_STAGES) ?
                             a2t_pkg::MAX_STAGES : CORDIC_STAGES;

    a2t_pkg::t_req  w_req;
    a2t_pkg::t_res  w_res;
    a2t_pkg::t_rot  w_rot [0:N_CELLS];
    logic           w_vld [0:N_CELLS];
    logic           w_rdy [0:N_CELLS];

    // unpack the request
    always_comb begin
        w_req.px  = $signed(s_axis_tdata[31:0]);
        w_req.py  = $signed(s_axis_tdata[63:32]);
        w_req.sx  = $signed(s_axis_tdata[87:64]);
        w_req.sy  = $signed(s_axis_tdata[111:88]);
        w_req.rot = $signed(s_axis_tdata[137:112]);
        w_req.qx  = $signed(s_axis_tdata[169:138]);
        w_req.qy  = $signed(s_axis_tdata[201:170]);
    end

    // front end: fold angle, scale pivot, seed the CORDIC vector
    a2t_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (w_req),
        .o_valid (w_vld[0]),
        .i_ready (w_rdy[0]),
        .o_rot   (w_rot[0])
    );

    // row of CORDIC cells, one micro-rotation each
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        a2t_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_rot   (w_rot[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_rot   (w_rot[g+1])
        );
    end

    // back end: products, rounding, clamping, result register
    a2t_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[N_CELLS]),
        .o_ready (w_rdy[N_CELLS]),
        .i_rot   (w_rot[N_CELLS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    // pack the result
    assign m_axis_tdata = {w_res.ty, w_res.tx, w_res.m11, w_res.m10, w_res.m01, w_res.m00};
    assign m_axis_tuser = w_res.ovf;

    // the front can only refuse when the whole row is full behind a held result
    `A2T_ASSERT_IMPLIES(a_backpressure_source, i_clk, i_rst_n, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

endmodule

FILE: tb/sv/tb_affine_2d_transform_builder_top.sv
//----------------------------------------------------------------------------
// tb_affine_2d_transform_builder_top
// Self-checking bench for the 2D affine transform builder. A directed table
// covers zero scale, every angle fold (quarter, half and full turn, both
// signs, encodings past a full turn), matrix clamping and translation
// saturation. Random requests follow in three idle/stall phases, one of them
// with a long output hold-off. Each result is compared field by field with a
// local fixed-point CORDIC predictor.
//----------------------------------------------------------------------------
module tb_affine_2d_transform_builder_top;

    localparam int     STAGES      = 16;
    localparam int     LATENCY     = STAGES + 6;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     RANDOM_REQS = 360;      // per phase
    localparam int     HOLD_CYCLES = 300;      // long output hold-off
    localparam int     NUM_DIRECT  = 24;

    // Angles, Q9.16 degrees at the port
    localparam int     DEG_30      = 1966080;
    localparam int     DEG_45      = 2949120;
    localparam int     DEG_90      = 5898240;
    localparam int     DEG_135     = 8847360;
    localparam int     DEG_180     = 11796480;
    localparam int     DEG_270     = 17694720;
    localparam int     DEG_360     = 23592960;

    // Internal angle units are 2^-22 degree
    localparam longint QUARTER_TURN = 64'sd377487360;
    localparam longint HALF_TURN    = 64'sd754974720;
    localparam longint FULL_TURN    = 64'sd1509949440;
    localparam longint CORDIC_GAIN  = 64'sd652032874;   // Q2.30

    localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
    localparam logic signed [23:0] S_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] S_MIN = 24'sh80_0000;
    localparam logic signed [23:0] S_ONE = 24'sd65536;

    localparam longint ATAN_DEG [24] = '{
        188743680, 111421900, 58872272, 29884485,
        15000234,  7507429,   3754631,  1877430,
        938729,    469366,    234683,   117342,
        58671,     29335,     14668,    7334,
        3667,      1833,      917,      458,
        229,       115,       57,       29
    };

    typedef struct {
        a2t_pkg::t_req req;
        bit            typed;      // 1: use want below instead of the predictor
        a2t_pkg::t_res want;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pivot_x[31:0] pivot_y[63:32] scale_x[87:64] scale_y[111:88]
    // rotation_deg[137:112] pos_x[169:138] pos_y[201:170], zero pad above
    logic [207:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // m00[23:0] m01[47:24] m10[71:48] m11[95:72] trans_x[127:96] trans_y[159:128]
    logic [159:0] m_axis_tdata;
    // overflow[0]
    logic [0:0]   m_axis_tuser;

    a2t_pkg::t_res want_xforms[$];      // predicted transforms, oldest first
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_off_req = 1'b0;

    affine_2d_transform_builder_top #(
        .CORDIC_STAGES(STAGES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    //------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------

    // Add half an LSB, then shift right arithmetically
    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // Clamp to a signed width; flag the clamp through hit
    function automatic longint clamp_w(input longint v, input int w, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic a2t_pkg::t_res predict_transform(input a2t_pkg::t_req r);
        longint        ang;
        longint        cx;
        longint        cy;
        longint        dx;
        longint        dy;
        longint        cosv;
        longint        sinv;
        longint        ax;
        longint        ay;
        bit            fold_neg;
        bit            sat_hit;
        bit            m_hit;
        a2t_pkg::t_res res;
        ang      = longint'(r.rot) * 64;
        fold_neg = 1'b0;
        sat_hit  = 1'b0;
        m_hit    = 1'b0;
        // bring into [-180, 180] with one full turn
        if (ang > HALF_TURN) begin
            ang -= FULL_TURN;
        end else if (ang < -HALF_TURN) begin
            ang += FULL_TURN;
        end
        // past a quarter turn: rotate by a half turn and negate the result
        if (ang > QUARTER_TURN) begin
            ang -= HALF_TURN;
            fold_neg = 1'b1;
        end else if (ang < -QUARTER_TURN) begin
            ang += HALF_TURN;
            fold_neg = 1'b1;
        end
        cx = CORDIC_GAIN;
        cy = 0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (ang >= 0) begin
                cx -= dx;
                cy += dy;
                ang -= ATAN_DEG[i];
            end else begin
                cx += dx;
                cy -= dy;
                ang += ATAN_DEG[i];
            end
        end
        cosv = fold_neg ? -cx : cx;
        sinv = fold_neg ? -cy : cy;

        // matrix clamps never raise overflow
        res.m00 = 24'(clamp_w(round_shift(longint'(r.sx) * cosv, 30), 24, m_hit));
        res.m01 = 24'(clamp_w(round_shift(longint'(r.sx) * sinv, 30), 24, m_hit));
        res.m10 = 24'(clamp_w(round_shift(-(longint'(r.sy) * sinv), 30), 24, m_hit));
        res.m11 = 24'(clamp_w(round_shift(longint'(r.sy) * cosv, 30), 24, m_hit));

        ax = clamp_w(round_shift(longint'(r.px) * longint'(r.sx), 16), 32, sat_hit);
        ay = clamp_w(round_shift(longint'(r.py) * longint'(r.sy), 16), 32, sat_hit);
        res.tx = 32'(clamp_w(round_shift(ax * cosv - ay * sinv, 30) + longint'(r.qx), 32,
                             sat_hit));
        res.ty = 32'(clamp_w(round_shift(ax * sinv + ay * cosv, 30) + longint'(r.qy), 32,
                             sat_hit));
        res.ovf = sat_hit;
        return res;
    endfunction

    //------------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------------

    // Positions and pivots: full range, a few units around zero, or an edge
    function automatic logic [31:0] pick_pos();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return int'($urandom_range(8388608)) - 4194304;
            2: begin
                case ($urandom_range(4))
                    0:       return P_MAX;
                    1:       return P_MIN;
                    2:       return 32'sd65536;
                    3:       return -32'sd65536;
                    default: return '0;
                endcase
            end
            default: return int'($urandom_range(1048576)) - 524288;
        endcase
    endfunction

    // Scales: full range, within plus or minus 4.0, or an edge
    function automatic logic [23:0] pick_scale();
        case ($urandom_range(3)) inside
            0:       return 24'($urandom());
            1, 2:    return 24'(int'($urandom_range(524288)) - 262144);
            default: begin
                case ($urandom_range(4))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return S_ONE;
                    3:       return -S_ONE;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic a2t_pkg::t_req rand_request();
        a2t_pkg::t_req r;
        r.px = pick_pos();
        r.py = pick_pos();
        r.qx = pick_pos();
        r.qy = pick_pos();
        r.sx = pick_scale();
        r.sy = pick_scale();
        // mostly legal angles, sometimes any 26-bit encoding
        if ($urandom_range(3) == 0) begin
            r.rot = 26'($urandom());
        end else begin
            r.rot = 26'(int'($urandom_range(2 * DEG_360)) - DEG_360);
        end
        return r;
    endfunction

    // Offer one request, hold it until accepted, then queue its prediction
    task automatic send_request(input a2t_pkg::t_req r, input bit typed,
                                input a2t_pkg::t_res typed_res);
        a2t_pkg::t_res want;
        want = typed ? typed_res : predict_transform(r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, r.qy, r.qx, r.rot, r.sy, r.sx, r.py, r.px};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        want_xforms.push_back(want);
    endtask

    // Directed table. Zero-scale rows are obvious: the matrix is zero and the
    // translation is the position. All other rows go through the predictor.
    t_stim_row directed_rows [NUM_DIRECT] = '{
        // everything zero
        '{'{32'sd0, 32'sd0, 24'sd0, 24'sd0, 26'sd0, 32'sd0, 32'sd0}, 1'b1,
          '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 32'sd0, 32'sd0, 1'b0}},
        // zero scale, extreme pivots and positions
        '{'{P_MAX, P_MIN, 24'sd0, 24'sd0, 26'(DEG_90), P_MAX, P_MIN}, 1'b1,
          '{24'sd0, 24'sd0, 24'sd0, 24'sd0, P_MAX, P_MIN, 1'b0}},
        // zero scale, angle encodings past a full turn
        '{'{P_MIN, P_MAX, 24'sd0, 24'sd0, 26'sh1FF_FFFF, P_MIN, P_MAX}, 1'b1,
          '{24'sd0, 24'sd0, 24'sd0, 24'sd0, P_MIN, P_MAX, 1'b0}},
        '{'{P_MAX, P_MAX, 24'sd0, 24'sd0, 26'sh200_0000, 32'sd12345, -32'sd777}, 1'b1,
          '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 32'sd12345, -32'sd777, 1'b0}},
        // unit scale and pivot through every fold of the angle
        '{'{32'sd65536, 32'sd65536, S_ONE, S_ONE, 26'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, S_ONE, S_ONE, 26'(DEG_90), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, S_ONE, S_ONE, 26'(-DEG_90), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, S_ONE, S_ONE, 26'(DEG_180), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, S_ONE, S_ONE, 26'(-DEG_180), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, S_ONE, S_ONE, 26'(DEG_360), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, S_ONE, S_ONE, 26'(-DEG_360), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, -32'sd65536, S_ONE, S_ONE, 26'(DEG_135), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, -32'sd65536, S_ONE, S_ONE, 26'(-DEG_135), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd131072, 32'sd65536, S_ONE, S_ONE, 26'(DEG_270), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd131072, 32'sd65536, S_ONE, S_ONE, 26'(-DEG_270), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd65536, 32'sd65536, S_ONE, -S_ONE, 26'(DEG_45), 32'sd65536, 32'sd0}, 1'b0,
          '0},
        // matrix terms at and past the clamp
        '{'{32'sd0, 32'sd0, S_MAX, S_MAX, 26'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, S_MIN, S_MIN, 26'(DEG_180), 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, S_MIN, S_MAX, 26'(DEG_90), 32'sd0, 32'sd0}, 1'b0, '0},
        // pivot product clamps high and low
        '{'{P_MAX, P_MAX, S_MAX, S_MAX, 26'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{P_MIN, P_MAX, S_MAX, S_MIN, 26'(DEG_30), 32'sd0, 32'sd0}, 1'b0, '0},
        // translation sum clamps high and low
        '{'{32'sd65536, 32'sd65536, S_ONE, S_ONE, 26'sd0, P_MAX, P_MAX}, 1'b0, '0},
        '{'{-32'sd65536, -32'sd65536, S_ONE, S_ONE, 26'sd0, P_MIN, P_MIN}, 1'b0, '0},
        '{'{32'sh1234_5678, -32'sh0765_4321, 24'sd98304, -24'sd40000, 26'(DEG_30),
            -32'sh0020_0000, 32'sh0011_0000}, 1'b0, '0}
    };

    //------------------------------------------------------------------------
    // Output side: random stall, with one long hold-off on request
    //------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                // hold off long enough that the pipe fills and stalls the input
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    //------------------------------------------------------------------------
    // Result check: compare each accepted result with the oldest prediction
    //------------------------------------------------------------------------
    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        a2t_pkg::t_res want;
        a2t_pkg::t_res got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.m00 = m_axis_tdata[23:0];
            got.m01 = m_axis_tdata[47:24];
            got.m10 = m_axis_tdata[71:48];
            got.m11 = m_axis_tdata[95:72];
            got.tx  = m_axis_tdata[127:96];
            got.ty  = m_axis_tdata[159:128];
            got.ovf = m_axis_tuser[0];
            if (want_xforms.size() == 0) begin
                $display("%0t: result with no request pending, expected none, got %h %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = want_xforms.pop_front();
                check_field("m00", longint'(want.m00), longint'(got.m00));
                check_field("m01", longint'(want.m01), longint'(got.m01));
                check_field("m10", longint'(want.m10), longint'(got.m10));
                check_field("m11", longint'(want.m11), longint'(got.m11));
                check_field("trans_x", longint'(want.tx), longint'(got.tx));
                check_field("trans_y", longint'(want.ty), longint'(got.ty));
                check_field("overflow", longint'(want.ovf), longint'(got.ovf));
            end
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_affine_2d_transform_builder_top: done, errors");
            $finish;
        end
    end

    //------------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, sender sparse and receiver busy
        send_idle_pct = 20;
        recv_idle_pct = 54;
        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].req, directed_rows[k].typed,
                         directed_rows[k].want);
        end

        // Random phases: receiver idles more, then sender, then neither
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_off_req  = 1'b1;
                end
            endcase
            repeat (RANDOM_REQS) send_request(rand_request(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give stray results time to show up
        while (want_xforms.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 16) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_affine_2d_transform_builder_top: done, clean");
        end else begin
            $display("tb_affine_2d_transform_builder_top: done, errors");
        end
        $finish;
    end

endmodule
